@@ hdl/rdq_pkg.sv @@
// ----------------------------------------------------------------------------
// rdq_pkg
// Shared request codes, status codes and control types for the reversible
// double-ended queue.
// ----------------------------------------------------------------------------
package rdq_pkg;

  localparam int REQ_W    = 4;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 10;
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 11;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_L  = 4'd0,
    REQ_PUSH_R  = 4'd1,
    REQ_POP_L   = 4'd2,
    REQ_POP_R   = 4'd3,
    REQ_GET     = 4'd4,
    REQ_SET     = 4'd5,
    REQ_PEEK_L  = 4'd6,
    REQ_PEEK_R  = 4'd7,
    REQ_REVERSE = 4'd8
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // Strobes for the single memory port.
  typedef struct packed {
    logic rd;
    logic wr;
  } mem_ctl_t;

endpackage

@@ hdl/rdq_mem.sv @@
// ----------------------------------------------------------------------------
// rdq_mem
// Single-port synchronous store for the queue entries, registered read data.
// ----------------------------------------------------------------------------
module rdq_mem #(
  parameter int DEPTH      = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic                     clk,
  input  rdq_pkg::mem_ctl_t        ctl,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [DATA_WIDTH-1:0]    wdata,
  output logic [DATA_WIDTH-1:0]    rdata
);

  logic [DATA_WIDTH-1:0] store [DEPTH];

  // The read data only moves on a read, so it holds while the result waits.
  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      store[addr] <= wdata;
    end
    if (ctl.rd) begin
      rdata <= store[addr];
    end
  end

endmodule

@@ hdl/rdq_ctrl.sv @@
// ----------------------------------------------------------------------------
// rdq_ctrl
// Queue bookkeeping: base slot, entry count and reverse flag, plus the slot
// address and port strobes for each accepted request.
// ----------------------------------------------------------------------------
module rdq_ctrl #(
  parameter int DEPTH      = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic [rdq_pkg::REQ_W-1:0]    req_type,
  input  logic [rdq_pkg::POS_W-1:0]    position,
  input  logic [DATA_WIDTH-1:0]        wdata_in,
  output rdq_pkg::mem_ctl_t            mem_ctl,
  output logic [$clog2(DEPTH)-1:0]     mem_addr,
  output logic [DATA_WIDTH-1:0]        mem_wdata,
  output rdq_pkg::status_t             status,
  output logic                         is_read,
  output logic [$clog2(DEPTH+1)-1:0]   count_after,
  output logic                         flag_after
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > rdq_pkg::POS_W) ? CW : rdq_pkg::POS_W;

  logic [AW-1:0] base;
  logic [CW-1:0] count;
  logic          flag;

  logic [AW-1:0] base_next;
  logic [CW-1:0] count_next;
  logic          flag_next;

  logic [AW-1:0] base_inc;
  logic [AW-1:0] base_dec;
  logic [AW-1:0] offset;
  logic [AW:0]   slot_sum;
  logic          use_front;
  logic          full;
  logic          empty;
  logic          in_range;
  rdq_pkg::mem_ctl_t ctl;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign in_range = (PW'(position) < PW'(count));
  assign base_inc = (base == AW'(DEPTH - 1)) ? '0 : base + AW'(1);
  assign base_dec = (base == '0) ? AW'(DEPTH - 1) : base - AW'(1);

  always_comb begin
    status     = rdq_pkg::ST_OK;
    ctl        = '0;
    offset     = '0;
    use_front  = 1'b0;
    base_next  = base;
    count_next = count;
    flag_next  = flag;
    case (rdq_pkg::req_t'(req_type))
      rdq_pkg::REQ_PUSH_L, rdq_pkg::REQ_PUSH_R: begin
        if (full) begin
          status = rdq_pkg::ST_FULL;
        end else begin
          ctl.wr     = 1'b1;
          count_next = count + CW'(1);
          // The physical front is used when the logical end and flag differ.
          if ((req_type == rdq_pkg::REQ_PUSH_L) != flag) begin
            use_front = 1'b1;
            base_next = base_dec;
          end else begin
            offset = AW'(count);
          end
        end
      end
      rdq_pkg::REQ_POP_L, rdq_pkg::REQ_POP_R: begin
        if (empty) begin
          status = rdq_pkg::ST_EMPTY;
        end else begin
          count_next = count - CW'(1);
          if ((req_type == rdq_pkg::REQ_POP_L) != flag) begin
            base_next = base_inc;
          end
        end
      end
      rdq_pkg::REQ_GET, rdq_pkg::REQ_SET: begin
        if (!in_range) begin
          status = rdq_pkg::ST_RANGE;
        end else begin
          ctl.rd = (req_type == rdq_pkg::REQ_GET);
          ctl.wr = (req_type == rdq_pkg::REQ_SET);
          offset = flag ? AW'(count - CW'(1) - CW'(position)) : AW'(position);
        end
      end
      rdq_pkg::REQ_PEEK_L, rdq_pkg::REQ_PEEK_R: begin
        if (empty) begin
          status = rdq_pkg::ST_EMPTY;
        end else begin
          ctl.rd = 1'b1;
          offset = ((req_type == rdq_pkg::REQ_PEEK_L) == flag) ?
                   AW'(count - CW'(1)) : '0;
        end
      end
      rdq_pkg::REQ_REVERSE: begin
        flag_next = ~flag;
      end
      default: begin
      end
    endcase
  end

  // Offsets stay below DEPTH, so one compare and subtract wraps the sum.
  assign slot_sum = {1'b0, base} + {1'b0, offset};

  always_comb begin
    if (use_front) begin
      mem_addr = base_dec;
    end else if (slot_sum >= (AW+1)'(DEPTH)) begin
      mem_addr = AW'(slot_sum - (AW+1)'(DEPTH));
    end else begin
      mem_addr = AW'(slot_sum);
    end
  end

  assign mem_ctl.rd  = accept & ctl.rd;
  assign mem_ctl.wr  = accept & ctl.wr;
  assign mem_wdata   = wdata_in;
  assign is_read     = ctl.rd;
  assign count_after = count_next;
  assign flag_after  = flag_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      base  <= '0;
      count <= '0;
      flag  <= 1'b0;
    end else if (accept) begin
      base  <= base_next;
      count <= count_next;
      flag  <= flag_next;
    end
  end

endmodule

@@ hdl/reversible_deque.sv @@
// ----------------------------------------------------------------------------
// reversible_deque
// Bounded double-ended queue in a circular single-port store, with a flag
// that swaps the two ends and the direction of indexing.
// ----------------------------------------------------------------------------
// A taken request goes through stage one and the output register in turn.
// Throughput: one request per cycle when not stalled; each request makes at
// most one access to the single memory port, and the pointer state is settled
// at acceptance. Reset clears the base slot, the entry count, the reverse flag
// and both stages; the entry store keeps its contents and needs no clearing.
// ----------------------------------------------------------------------------
module reversible_deque #(
  parameter int DEPTH      = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // Request channel.
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [rdq_pkg::REQ_W-1:0]             req_type,
  input  logic [rdq_pkg::POS_W-1:0]             position,
  input  logic signed [rdq_pkg::VALUE_W-1:0]    value,
  // Result channel.
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [rdq_pkg::STATUS_W-1:0]          status,
  output logic signed [rdq_pkg::VALUE_W-1:0]    read_value,
  output logic [rdq_pkg::COUNT_W-1:0]           count,
  output logic                                  is_reversed
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic                  accept;
  logic [DATA_WIDTH-1:0] value_ext;

  rdq_pkg::mem_ctl_t     mem_ctl;
  logic [AW-1:0]         mem_addr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic [DATA_WIDTH-1:0] mem_rdata;

  rdq_pkg::status_t      req_status;
  logic                  req_is_read;
  logic [CW-1:0]         req_count;
  logic                  req_flag;

  // Stage one: the memory access cycle. Its registers carry everything about
  // the result except the read data, which the memory itself registers.
  logic                  s1_valid;
  rdq_pkg::status_t      s1_status;
  logic                  s1_is_read;
  logic [CW-1:0]         s1_count;
  logic                  s1_flag;
  logic                  s1_advance;

  // The value is sign-extended, or cut down, to the stored word width.
  assign value_ext = DATA_WIDTH'(value);

  // Stage one moves on whenever the output register is free or being taken.
  // A new read is only issued when stage one moves on or is empty, so the
  // memory's read data stays put for as long as stage one is held.
  assign s1_advance = !out_valid || !out_stall;
  assign in_stall   = s1_valid && !s1_advance;
  assign accept     = in_valid && !in_stall;

  rdq_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .req_type    (req_type),
    .position    (position),
    .wdata_in    (value_ext),
    .mem_ctl     (mem_ctl),
    .mem_addr    (mem_addr),
    .mem_wdata   (mem_wdata),
    .status      (req_status),
    .is_read     (req_is_read),
    .count_after (req_count),
    .flag_after  (req_flag)
  );

  rdq_mem #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_mem (
    .clk   (clk),
    .ctl   (mem_ctl),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // An empty stage one takes a new beat even while the output register is
  // held; a full one only changes when it moves on.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_advance || !s1_valid) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status  <= req_status;
      s1_is_read <= req_is_read;
      s1_count   <= req_count;
      s1_flag    <= req_flag;
    end
  end

  // Output register: parts the result channel from the request side, so a
  // new request is taken into an empty stage one while a finished result waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_valid) begin
      status      <= s1_status;
      // Stored words read back zero-extended, or cut to the port width.
      read_value  <= s1_is_read ? rdq_pkg::VALUE_W'(mem_rdata) : '0;
      count       <= rdq_pkg::COUNT_W'(s1_count);
      is_reversed <= s1_flag;
    end
  end

endmodule

@@ hdl/rdq_checker.sv @@
// ----------------------------------------------------------------------------
// rdq_checker
// Port-level checks for the reversible double-ended queue, bound to the top.
// ----------------------------------------------------------------------------
module rdq_checker #(
  parameter int DEPTH = 1024
) (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [rdq_pkg::STATUS_W-1:0]       status,
  input logic signed [rdq_pkg::VALUE_W-1:0] read_value,
  input logic [rdq_pkg::COUNT_W-1:0]        count,
  input logic                               is_reversed
);

  // A stalled result beat stays offered with the same payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) &&
      $stable(read_value) && $stable(count) && $stable(is_reversed))
    else $error("stalled result beat changed");

  // A failed request returns no data.
  a_read_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != rdq_pkg::ST_OK) |-> read_value == '0)
    else $error("failed request returned data");

  // A full status means the store is full, an empty status means it is empty.
  a_full_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((status != rdq_pkg::ST_FULL) ||
                   (count == rdq_pkg::COUNT_W'(DEPTH))) &&
                  ((status != rdq_pkg::ST_EMPTY) || (count == '0)))
    else $error("status disagrees with count");

  // The request side is only held back while a result beat is held back.
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("request stalled with the result side free");

  // Reset empties the result stage.
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat offered after reset");

endmodule

bind reversible_deque rdq_checker #(.DEPTH(DEPTH)) u_rdq_checker (.*);
